/* sv/palc_pkg.sv */
// ----------------------------------------------------------------------------
// palc_pkg
// Types, sizes and helpers shared by the positional array list cells and core.
// ----------------------------------------------------------------------------
package palc_pkg;

   localparam int CAPACITY      = 32;
   localparam int ELEMENT_WIDTH = 32;

   localparam int OP_W    = 2;
   localparam int POS_W   = 6;
   localparam int VALUE_W = 32;
   localparam int LEN_W   = 6;

   localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W   = ((COUNT_W > POS_W) ? COUNT_W : POS_W) + 1;

   typedef logic [ELEMENT_WIDTH-1:0] elem_type;

   typedef enum logic [OP_W-1:0] {
      OP_GET    = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2,
      OP_LOCATE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_LOAD,
      CELL_FROM_LEFT,
      CELL_FROM_RIGHT
   } cell_op_type;

   typedef struct packed {
      cell_op_type cell_op;
      logic        read_sel;
      logic        search_en;
   } cell_ctrl_type;

   typedef struct packed {
      op_type                    op;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic                      status;
      logic signed [VALUE_W-1:0] read_value;
      logic [POS_W-1:0]          found_position;
      logic [LEN_W-1:0]          list_length;
   } rsp_type;

   // Sign extend the request word, then cut to the stored width.
   function automatic elem_type to_elem(input logic [VALUE_W-1:0] v);
      logic signed [63:0] ext;
      ext = 64'(signed'(v));
      return ext[ELEMENT_WIDTH-1:0];
   endfunction

   // Zero extend the stored word, then keep the low result bits.
   function automatic logic [VALUE_W-1:0] from_elem(input elem_type e);
      logic [63:0] ext;
      ext = 64'(e);
      return ext[VALUE_W-1:0];
   endfunction

endpackage

/* sv/palc_cell.sv */
// ----------------------------------------------------------------------------
// palc_cell
// One list slot: holds an entry, loads, shifts from a neighbor, compares.
// ----------------------------------------------------------------------------
module palc_cell (
   input  logic                    clock,
   input  palc_pkg::cell_ctrl_type ctrl,
   input  palc_pkg::elem_type      new_value,
   input  palc_pkg::elem_type      left_value,
   input  palc_pkg::elem_type      right_value,
   input  palc_pkg::elem_type      key,
   output palc_pkg::elem_type      value,
   output logic                    match,
   output palc_pkg::elem_type      read_data
);

   palc_pkg::elem_type data_ff;
   palc_pkg::elem_type data_in;

   always_comb begin
      unique case (ctrl.cell_op)
         palc_pkg::CELL_LOAD:       data_in = new_value;
         palc_pkg::CELL_FROM_LEFT:  data_in = left_value;
         palc_pkg::CELL_FROM_RIGHT: data_in = right_value;
         default:                   data_in = data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign value     = data_ff;
   assign match     = ctrl.search_en && (data_ff == key);
   assign read_data = ctrl.read_sel ? data_ff : '0;

endmodule

/* sv/palc_collect.sv */
// ----------------------------------------------------------------------------
// palc_collect
// Gathers the addressed entry and the first matching position from the cells.
// ----------------------------------------------------------------------------
module palc_collect (
   input  logic [palc_pkg::CAPACITY-1:0]   match,
   input  palc_pkg::elem_type              read_data [palc_pkg::CAPACITY],
   output palc_pkg::elem_type              read_value,
   output logic [palc_pkg::COUNT_W-1:0]    found_position
);

   logic [palc_pkg::CAPACITY-1:0] first;
   logic [palc_pkg::IDX_W-1:0]    idx;
   palc_pkg::elem_type            acc;

   always_comb begin
      // isolate the lowest set match bit
      first = match & (~match + palc_pkg::CAPACITY'(1));
      acc   = '0;
      idx   = '0;
      for (int i = 0; i < palc_pkg::CAPACITY; i++) begin
         acc = acc | read_data[i];
         if (first[i]) begin
            idx = idx | palc_pkg::IDX_W'(i);
         end
      end
      read_value     = acc;
      found_position = (|match) ? palc_pkg::COUNT_W'(idx) + palc_pkg::COUNT_W'(1) : '0;
   end

endmodule

/* sv/positional_array_list_core.sv */
// ----------------------------------------------------------------------------
// positional_array_list_core
// Bounded ordered list of signed words addressed by 1-based position.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item: op (get, insert, delete, locate), position and
//   element_value. rsp_* returns one item per request: status, read_value,
//   found_position and list_length after the request.
//   An item is taken on an edge with valid high and stall low.
//   Results are registered and appear in the next cycle. Throughput: one item
//   per cycle unless stalled. Every cell shifts, loads or holds in the same
//   cycle, and locate compares all cells at once and encodes the first match;
//   the result register is the only buffer between the two sides.
//   While a result waits under rsp_stall, req_stall is high; it drops in the
//   cycle the result is taken, so a new item moves in on that same edge.
//   Reset empties the list and drops any pending result; no clearing pass,
//   the entries above the length are never read.
//   Errors (full, empty, position out of range) leave the list unchanged.
// ----------------------------------------------------------------------------
module positional_array_list_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  palc_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output palc_pkg::rsp_type rsp_data
);

   logic [palc_pkg::COUNT_W-1:0] count_ff;
   logic [palc_pkg::COUNT_W-1:0] count_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   palc_pkg::rsp_type            rsp_ff;
   palc_pkg::rsp_type            rsp_in;

   logic                         req_fire;
   logic [palc_pkg::CMP_W-1:0]   pos_c;
   logic [palc_pkg::CMP_W-1:0]   cnt_c;
   logic [palc_pkg::CMP_W-1:0]   slot_c;
   logic                         read_ok;
   logic                         insert_ok;
   logic                         delete_ok;
   palc_pkg::elem_type           key;

   palc_pkg::cell_ctrl_type      ctrl  [palc_pkg::CAPACITY];
   palc_pkg::elem_type           value [palc_pkg::CAPACITY];
   palc_pkg::elem_type           rdata [palc_pkg::CAPACITY];
   logic [palc_pkg::CAPACITY-1:0] match;
   palc_pkg::elem_type           read_value;
   logic [palc_pkg::COUNT_W-1:0] found_position;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   always_comb begin
      pos_c     = palc_pkg::CMP_W'(req_data.position);
      cnt_c     = palc_pkg::CMP_W'(count_ff);
      slot_c    = pos_c - palc_pkg::CMP_W'(1);
      read_ok   = (pos_c != '0) && (pos_c <= cnt_c);
      insert_ok = (cnt_c < palc_pkg::CMP_W'(palc_pkg::CAPACITY)) && (pos_c != '0)
                  && (pos_c <= cnt_c + palc_pkg::CMP_W'(1));
      delete_ok = read_ok;
      key       = palc_pkg::to_elem(req_data.element_value);
   end

   // per-cell control: each cell compares its own slot to the request
   for (genvar i = 0; i < palc_pkg::CAPACITY; i++) begin : g_cell
      localparam logic [palc_pkg::CMP_W-1:0] CELL_POS = palc_pkg::CMP_W'(i);

      always_comb begin
         ctrl[i].cell_op   = palc_pkg::CELL_HOLD;
         ctrl[i].read_sel  = (CELL_POS == slot_c);
         ctrl[i].search_en = (CELL_POS < cnt_c);
         if (req_fire) begin
            unique case (req_data.op)
               palc_pkg::OP_INSERT: begin
                  if (insert_ok && CELL_POS == slot_c) begin
                     ctrl[i].cell_op = palc_pkg::CELL_LOAD;
                  end else if (insert_ok && CELL_POS > slot_c) begin
                     ctrl[i].cell_op = palc_pkg::CELL_FROM_LEFT;
                  end
               end
               palc_pkg::OP_DELETE: begin
                  if (delete_ok && CELL_POS >= slot_c) begin
                     ctrl[i].cell_op = palc_pkg::CELL_FROM_RIGHT;
                  end
               end
               default: ctrl[i].cell_op = palc_pkg::CELL_HOLD;
            endcase
         end
      end

      if (i == 0) begin : g_first
         if (palc_pkg::CAPACITY > 1) begin : g_more
            palc_cell u_cell (
               .clock       (clock),
               .ctrl        (ctrl[i]),
               .new_value   (key),
               .left_value  (key),
               .right_value (value[i+1]),
               .key         (key),
               .value       (value[i]),
               .match       (match[i]),
               .read_data   (rdata[i])
            );
         end else begin : g_only
            palc_cell u_cell (
               .clock       (clock),
               .ctrl        (ctrl[i]),
               .new_value   (key),
               .left_value  (key),
               .right_value (value[i]),
               .key         (key),
               .value       (value[i]),
               .match       (match[i]),
               .read_data   (rdata[i])
            );
         end
      end else if (i == palc_pkg::CAPACITY - 1) begin : g_last
         palc_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl[i]),
            .new_value   (key),
            .left_value  (value[i-1]),
            .right_value (value[i]),
            .key         (key),
            .value       (value[i]),
            .match       (match[i]),
            .read_data   (rdata[i])
         );
      end else begin : g_mid
         palc_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl[i]),
            .new_value   (key),
            .left_value  (value[i-1]),
            .right_value (value[i+1]),
            .key         (key),
            .value       (value[i]),
            .match       (match[i]),
            .read_data   (rdata[i])
         );
      end
   end

   palc_collect u_collect (
      .match          (match),
      .read_data      (rdata),
      .read_value     (read_value),
      .found_position (found_position)
   );

   always_comb begin
      count_in       = count_ff;
      rsp_in         = rsp_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (req_fire) begin
         rsp_valid_in          = 1'b1;
         rsp_in.status         = 1'b0;
         rsp_in.read_value     = '0;
         rsp_in.found_position = '0;
         unique case (req_data.op)
            palc_pkg::OP_GET: begin
               if (read_ok) begin
                  rsp_in.read_value = palc_pkg::from_elem(read_value);
               end else begin
                  rsp_in.status = 1'b1;
               end
            end
            palc_pkg::OP_INSERT: begin
               if (insert_ok) begin
                  count_in = count_ff + palc_pkg::COUNT_W'(1);
               end else begin
                  rsp_in.status = 1'b1;
               end
            end
            palc_pkg::OP_DELETE: begin
               if (delete_ok) begin
                  rsp_in.read_value = palc_pkg::from_elem(read_value);
                  count_in          = count_ff - palc_pkg::COUNT_W'(1);
               end else begin
                  rsp_in.status = 1'b1;
               end
            end
            default: begin
               rsp_in.found_position = palc_pkg::POS_W'(found_position);
            end
         endcase
         rsp_in.list_length = palc_pkg::LEN_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= palc_pkg::COUNT_W'(palc_pkg::CAPACITY))
      else $error("list length above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      req_fire && req_data.op == palc_pkg::OP_INSERT && insert_ok
      |=> count_ff == $past(count_ff) + palc_pkg::COUNT_W'(1))
      else $error("accepted insert did not grow the list");

   a_length_tracks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.list_length == palc_pkg::LEN_W'(count_ff))
      else $error("reported length differs from list length");

   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status |-> rsp_ff.read_value == '0
      && rsp_ff.found_position == '0)
      else $error("error result carries data");

endmodule

/* test/positional_array_list_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_core_test
// Drives get, insert, delete and locate items through the list core and checks
// each result against a predicted copy of the list, under random idling on
// both channels.
// ----------------------------------------------------------------------------
import palc_pkg::*;

class list_scoreboard;
   elem_type    slots [CAPACITY];
   int          count  = 0;
   int unsigned faults = 0;
   rsp_type     pending [$];

   // Apply one accepted item to the shadow list and queue its result.
   function void note_request(input req_type r);
      rsp_type     e;
      elem_type    v;
      logic [63:0] wide;
      int          p;
      wide = {{32{r.element_value[VALUE_W-1]}}, r.element_value};
      v    = wide[ELEMENT_WIDTH-1:0];
      p    = r.position;
      e    = '0;
      case (r.op)
         OP_GET: begin
            if (p < 1 || p > count) begin
               e.status = 1'b1;
            end else begin
               wide = 64'(slots[p-1]);
               e.read_value = wide[VALUE_W-1:0];
            end
         end
         OP_INSERT: begin
            if (count >= CAPACITY || p < 1 || p > count + 1) begin
               e.status = 1'b1;
            end else begin
               for (int k = count; k >= p; k--) slots[k] = slots[k-1];
               slots[p-1] = v;
               count++;
            end
         end
         OP_DELETE: begin
            if (count == 0 || p < 1 || p > count) begin
               e.status = 1'b1;
            end else begin
               wide = 64'(slots[p-1]);
               e.read_value = wide[VALUE_W-1:0];
               for (int k = p; k < count; k++) slots[k-1] = slots[k];
               count--;
            end
         end
         default: begin
            for (int k = 0; k < count; k++) begin
               if (slots[k] == v && e.found_position == '0) e.found_position = POS_W'(k + 1);
            end
         end
      endcase
      e.list_length = LEN_W'(count);
      pending.push_back(e);
   endfunction

   function void check_response(input rsp_type got);
      rsp_type e;
      if (pending.size() == 0) begin
         faults++;
         if (faults <= 10)
            $display("%0t: result with nothing pending: status=%0d read=%0d found=%0d len=%0d",
                     $realtime, got.status, got.read_value, got.found_position,
                     got.list_length);
         return;
      end
      e = pending.pop_front();
      if (got.status !== e.status || got.read_value !== e.read_value ||
          got.found_position !== e.found_position || got.list_length !== e.list_length) begin
         faults++;
         if (faults <= 10)
            $display("%0t: mismatch exp status=%0d read=%0d found=%0d len=%0d",
                     $realtime, e.status, e.read_value, e.found_position, e.list_length,
                     " got status=%0d read=%0d found=%0d len=%0d",
                     got.status, got.read_value, got.found_position, got.list_length);
      end
   endfunction
endclass

module positional_array_list_core_test;

   localparam int STUCK_LIMIT = 4000;
   localparam int PHASE_ITEMS = 170;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   list_scoreboard board = new();
   int          send_idle_pct = 12;
   int          recv_idle_pct = 66;
   int unsigned stuck         = 0;
   bit          growing       = 1'b1;

   positional_array_list_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result side: check on acceptance, then pick the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck <= 0;
      end else begin
         stuck <= stuck + 1;
      end
      if (stuck >= STUCK_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic issue(input op_type op, input int pos, input logic [VALUE_W-1:0] value);
      req_type r;
      r.op            = op;
      r.position      = POS_W'(pos);
      r.element_value = value;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      board.note_request(r);
   endtask

   function automatic logic [VALUE_W-1:0] pick_value(input int stored_pct);
      int pick;
      pick = $urandom_range(99);
      if (board.count > 0 && pick < stored_pct)
         return VALUE_W'(board.slots[$urandom_range(board.count - 1)]);
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'hffff_ffff;
         3:       return 32'h0;
         default: return $urandom;
      endcase
   endfunction

   // Swing the list between empty and full so both ends are hit repeatedly.
   task automatic issue_random();
      int     n;
      int     pick;
      op_type op;
      n = board.count;
      if (growing && n == CAPACITY) growing = 1'b0;
      else if (!growing && n == 0) growing = 1'b1;
      pick = $urandom_range(99);
      if (pick < 8) begin
         op = op_type'($urandom_range(3));
         issue(op, $urandom_range(63), $urandom);
      end else begin
         if (pick < 60)      op = growing ? OP_INSERT : OP_DELETE;
         else if (pick < 75) op = OP_GET;
         else if (pick < 85) op = growing ? OP_DELETE : OP_INSERT;
         else                op = OP_LOCATE;
         case (op)
            OP_INSERT: issue(op, $urandom_range(n + 1, 1), pick_value(25));
            OP_LOCATE: issue(op, $urandom_range(63), pick_value(60));
            default:   issue(op, (n == 0) ? 1 : $urandom_range(n, 1), $urandom);
         endcase
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty list corners.
      issue(OP_GET,    1, 32'd5);
      issue(OP_DELETE, 1, 32'd0);
      issue(OP_LOCATE, 0, 32'd0);
      issue(OP_INSERT, 0, 32'd1);
      issue(OP_INSERT, 2, 32'd1);
      // Build a short list with extreme values.
      issue(OP_INSERT, 1, 32'h8000_0000);
      issue(OP_INSERT, 1, 32'h7fff_ffff);
      issue(OP_INSERT, 3, 32'hffff_ffff);
      issue(OP_INSERT, 2, 32'h0);
      issue(OP_INSERT, 6, 32'h1234_5678);
      issue(OP_GET,    0, 32'h0);
      issue(OP_GET,   63, 32'h0);
      issue(OP_GET,    5, 32'h0);
      for (int i = 1; i <= 4; i++) issue(OP_GET, i, 32'h0);
      issue(OP_LOCATE, 63, 32'h8000_0000);
      issue(OP_LOCATE, 0, 32'hffff_ffff);
      issue(OP_LOCATE, 0, 32'd12345);
      issue(OP_DELETE, 5, 32'h0);
      issue(OP_DELETE, 63, 32'h0);
      issue(OP_DELETE, 0, 32'h0);
      issue(OP_DELETE, 2, 32'h0);
      issue(OP_DELETE, 1, 32'h0);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 66 : 0;
         recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 12 : 0;
         for (int i = 0; i < PHASE_ITEMS; i++) issue_random();
      end

      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (5) @(posedge clock);

      if (board.faults == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
